### hw/rtl/pip_pkg.sv
// Shared types and constants of the point-in-polygon set.
`default_nettype none

package pip_pkg;

	localparam int OP_W    = 2;
	localparam int ID_W    = 3;
	localparam int COORD_W = 16;
	localparam int INDEX_W = 3;

	typedef enum logic [OP_W-1:0] {
		OP_CLEAR  = 2'd0,
		OP_APPEND = 2'd1,
		OP_QUERY  = 2'd2
	} op_t;

	typedef struct packed {
		logic clear;
		logic append;
		logic start_query;
		logic next_poly;
		logic read;
		logic close;
		logic load_result;
		logic found;
	} pip_cmd_t;

	typedef struct packed {
		logic poly_short;
		logic last_vert;
		logic last_poly;
		logic pipe_busy;
		logic odd;
	} pip_status_t;

endpackage

`default_nettype wire

### hw/rtl/pip_req_if.sv
// Request channel: clear, append-vertex and query items.
`default_nettype none

interface pip_req_if import pip_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic [OP_W-1:0]            operation;
	logic [ID_W-1:0]            polygon_id;
	logic signed [COORD_W-1:0]  coord_x;
	logic signed [COORD_W-1:0]  coord_y;

	modport source (output valid, operation, polygon_id, coord_x, coord_y, input ready);
	modport sink   (input valid, operation, polygon_id, coord_x, coord_y, output ready);
endinterface

`default_nettype wire

### hw/rtl/pip_rsp_if.sv
// Response channel: query results.
`default_nettype none

interface pip_rsp_if import pip_pkg::*; ();
	logic               valid;
	logic               ready;
	logic               contained;
	logic [INDEX_W-1:0] polygon_index;

	modport source (output valid, contained, polygon_index, input ready);
	modport sink   (input valid, contained, polygon_index, output ready);
endinterface

`default_nettype wire

### hw/rtl/pip_ctrl.sv
// Controller state machine: item decode, polygon/edge walk sequencing, result handoff.
`default_nettype none

module pip_ctrl import pip_pkg::*; (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            req_valid,
	input  wire logic [OP_W-1:0] req_op,
	output logic                 req_ready,
	output logic                 rsp_valid,
	input  wire logic            rsp_ready,
	output pip_cmd_t             cmd,
	input  wire pip_status_t     st
);

	typedef enum logic [5:0] {
		S_IDLE   = 6'b000001,
		S_POLY   = 6'b000010,
		S_READ   = 6'b000100,
		S_CLOSE  = 6'b001000,
		S_DRAIN  = 6'b010000,
		S_FINISH = 6'b100000
	} state_t;

	state_t state_q, state_d;
	logic   found_q, found_d;
	logic   out_valid_q;

	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = out_valid_q;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		found_d = found_q;
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					case (req_op)
						OP_CLEAR:  cmd.clear = 1'b1;
						OP_APPEND: cmd.append = 1'b1;
						OP_QUERY: begin
							cmd.start_query = 1'b1;
							state_d         = S_POLY;
						end
						default: ;
					endcase
				end
			end
			S_POLY: begin
				// fewer than two vertices: no edge can be crossed
				if (st.poly_short) begin
					if (st.last_poly) begin
						found_d = 1'b0;
						state_d = S_FINISH;
					end else begin
						cmd.next_poly = 1'b1;
					end
				end else begin
					state_d = S_READ;
				end
			end
			S_READ: begin
				cmd.read = 1'b1;
				if (st.last_vert) state_d = S_CLOSE;
			end
			S_CLOSE: begin
				cmd.close = 1'b1;
				state_d   = S_DRAIN;
			end
			S_DRAIN: begin
				if (!st.pipe_busy) begin
					if (st.odd) begin
						found_d = 1'b1;
						state_d = S_FINISH;
					end else if (st.last_poly) begin
						found_d = 1'b0;
						state_d = S_FINISH;
					end else begin
						cmd.next_poly = 1'b1;
						state_d       = S_POLY;
					end
				end
			end
			S_FINISH: begin
				if (!out_valid_q || rsp_ready) begin
					cmd.load_result = 1'b1;
					cmd.found       = found_q;
					state_d         = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			found_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			found_q <= found_d;
			if (cmd.load_result) out_valid_q <= 1'b1;
			else if (rsp_ready)  out_valid_q <= 1'b0;
		end
	end

endmodule

`default_nettype wire

### hw/rtl/pip_dpath.sv
// Datapath: vertex memory, vertex counts, walk counters, edge-crossing pipeline, result register.
`default_nettype none

module pip_dpath import pip_pkg::*; #(
	parameter int MAX_VERTS  = 32,
	parameter int NUM_POLYS  = 8,
	parameter int COORD_BITS = 16
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire pip_cmd_t                  cmd,
	output pip_status_t                    st,
	input  wire logic [ID_W-1:0]           polygon_id,
	input  wire logic signed [COORD_W-1:0] coord_x,
	input  wire logic signed [COORD_W-1:0] coord_y,
	output logic                           contained,
	output logic [INDEX_W-1:0]             polygon_index
);

	localparam int CW        = (COORD_BITS < COORD_W) ? COORD_BITS : COORD_W;
	localparam int PW        = (NUM_POLYS > 1) ? $clog2(NUM_POLYS) : 1;
	localparam int VW        = $clog2(MAX_VERTS);
	localparam int CNTW      = $clog2(MAX_VERTS + 1);
	localparam int AW        = PW + VW;
	localparam int MEM_DEPTH = 2 ** AW;
	localparam int DW        = CW + 1;
	localparam int PRW       = 2 * DW;
	localparam int SW        = PRW + 1;

	// vertex word: {y, x}
	logic [2*CW-1:0]   mem [MEM_DEPTH];
	logic [CNTW-1:0]   counts_q [NUM_POLYS];

	logic [PW-1:0]     p_q;
	logic [VW-1:0]     j_q;
	logic signed [CW-1:0] px_q, py_q;

	logic [PW-1:0]     id_p;
	logic              id_ok;
	logic [PW-1:0]     cnt_idx;
	logic [CNTW-1:0]   cnt_sel;
	logic              wr_en;

	logic [2*CW-1:0]   rd_data_q;
	logic [2*CW-1:0]   prev_q, first_q;
	logic              rd_valid_s1, first_s1, close_s1;

	logic [2*CW-1:0]   edge_b;
	logic signed [CW-1:0] ax, ay, bx, by;
	logic              edge_valid_s1;

	logic              valid_s2;
	logic signed [DW-1:0] ex_s2, ey_s2, dy_s2, dx_s2;

	logic              valid_s3, range_s3, pos_s3;
	logic signed [PRW-1:0] prod_a_s3, prod_b_s3;
	logic signed [SW-1:0]  sum_s3;
	logic              hit_s3;

	logic              parity_q;
	logic              contained_q;
	logic [INDEX_W-1:0] index_q;

	assign id_p    = PW'(polygon_id);
	assign id_ok   = (32'(polygon_id) < NUM_POLYS);
	assign cnt_idx = cmd.append ? id_p : p_q;
	assign cnt_sel = counts_q[cnt_idx];
	assign wr_en   = cmd.append && id_ok && (cnt_sel < CNTW'(MAX_VERTS));

	always_ff @(posedge clk) begin
		if (wr_en) mem[{id_p, VW'(cnt_sel)}] <= {CW'(coord_y), CW'(coord_x)};
		if (cmd.read) rd_data_q <= mem[{p_q, j_q}];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_POLYS; i++) counts_q[i] <= '0;
		end else if (cmd.clear) begin
			for (int i = 0; i < NUM_POLYS; i++) counts_q[i] <= '0;
		end else if (wr_en) begin
			counts_q[id_p] <= cnt_sel + CNTW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			p_q <= '0;
			j_q <= '0;
		end else if (cmd.start_query) begin
			p_q <= '0;
			j_q <= '0;
		end else if (cmd.next_poly) begin
			p_q <= p_q + PW'(1);
			j_q <= '0;
		end else if (cmd.read) begin
			j_q <= j_q + VW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start_query) begin
			px_q <= CW'(coord_x);
			py_q <= CW'(coord_y);
		end
	end

	// stage 1: pair the returned vertex with the previous one, or close the loop
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_valid_s1 <= 1'b0;
			first_s1    <= 1'b0;
			close_s1    <= 1'b0;
		end else begin
			rd_valid_s1 <= cmd.read;
			first_s1    <= cmd.read && (j_q == '0);
			close_s1    <= cmd.close;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_valid_s1) begin
			prev_q <= rd_data_q;
			if (first_s1) first_q <= rd_data_q;
		end
	end

	assign edge_b        = close_s1 ? first_q : rd_data_q;
	assign ax            = $signed(prev_q[CW-1:0]);
	assign ay            = $signed(prev_q[2*CW-1:CW]);
	assign bx            = $signed(edge_b[CW-1:0]);
	assign by            = $signed(edge_b[2*CW-1:CW]);
	assign edge_valid_s1 = (rd_valid_s1 && !first_s1) || close_s1;

	// stage 2: differences
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_s2 <= 1'b0;
		else         valid_s2 <= edge_valid_s1;
	end

	always_ff @(posedge clk) begin
		ex_s2 <= DW'(bx) - DW'(ax);
		ey_s2 <= DW'(by) - DW'(ay);
		dy_s2 <= DW'(py_q) - DW'(ay);
		dx_s2 <= DW'(ax) - DW'(px_q);
	end

	// stage 3: cross products and the y-span test
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_s3 <= 1'b0;
		else         valid_s3 <= valid_s2;
	end

	always_ff @(posedge clk) begin
		prod_a_s3 <= PRW'(dx_s2) * PRW'(ey_s2);
		prod_b_s3 <= PRW'(dy_s2) * PRW'(ex_s2);
		pos_s3    <= (ey_s2 > 0);
		if (ey_s2 > 0)      range_s3 <= (dy_s2 >= 0) && (dy_s2 <= ey_s2);
		else if (ey_s2 < 0) range_s3 <= (dy_s2 <= 0) && (dy_s2 >= ey_s2);
		else                range_s3 <= 1'b0;
	end

	assign sum_s3 = SW'(prod_a_s3) + SW'(prod_b_s3);
	assign hit_s3 = valid_s3 && range_s3 &&
		(pos_s3 ? !sum_s3[SW-1] : (sum_s3[SW-1] || (sum_s3 == '0)));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) parity_q <= 1'b0;
		else if (cmd.start_query || cmd.next_poly) parity_q <= 1'b0;
		else if (hit_s3) parity_q <= ~parity_q;
	end

	always_ff @(posedge clk) begin
		if (cmd.load_result) begin
			contained_q <= cmd.found;
			index_q     <= cmd.found ? INDEX_W'(p_q) : '0;
		end
	end

	assign contained     = contained_q;
	assign polygon_index = index_q;

	assign st.poly_short = (cnt_sel < CNTW'(2));
	assign st.last_vert  = (CNTW'(j_q) == (cnt_sel - CNTW'(1)));
	assign st.last_poly  = (p_q == PW'(NUM_POLYS - 1));
	assign st.pipe_busy  = rd_valid_s1 || close_s1 || valid_s2 || valid_s3;
	assign st.odd        = parity_q;

endmodule

`default_nettype wire

### hw/rtl/point_in_polygon_set.sv
// Top level of the point-in-polygon set: controller plus datapath.
//
//  channel | dir | handshake     | payload
//  req     | in  | valid/ready   | operation, polygon_id, coord_x, coord_y
//  rsp     | out | valid/ready   | contained, polygon_index (queries only)
//
// Clear and append items leave req ready for the next item. A query walks
// polygons in order from 0; it stops at the first polygon with an odd count.
// The single-port vertex memory is read one vertex per cycle.
// Reset clears the vertex counts; stored vertices are left as they are.
// req is held off during a query; a new item is taken while a result waits on rsp.
`default_nettype none

module point_in_polygon_set import pip_pkg::*; #(
	parameter int MAX_VERTS  = 32,
	parameter int NUM_POLYS  = 8,
	parameter int COORD_BITS = 16
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	pip_req_if.sink    req,
	pip_rsp_if.source  rsp
);

	pip_cmd_t    cmd;
	pip_status_t st;

	pip_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_op    (req.operation),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.cmd       (cmd),
		.st        (st)
	);

	pip_dpath #(
		.MAX_VERTS  (MAX_VERTS),
		.NUM_POLYS  (NUM_POLYS),
		.COORD_BITS (COORD_BITS)
	) u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.st            (st),
		.polygon_id    (req.polygon_id),
		.coord_x       (req.coord_x),
		.coord_y       (req.coord_y),
		.contained     (rsp.contained),
		.polygon_index (rsp.polygon_index)
	);

endmodule

`default_nettype wire

### hw/rtl/pip_chk.sv
// Port-level checker for the point-in-polygon set, bound to the top level.
`default_nettype none

module pip_chk import pip_pkg::*; (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               req_valid,
	input wire logic               req_ready,
	input wire logic [OP_W-1:0]    req_operation,
	input wire logic               rsp_valid,
	input wire logic               rsp_ready,
	input wire logic               rsp_contained,
	input wire logic [INDEX_W-1:0] rsp_polygon_index
);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("rsp valid dropped while stalled");

	a_rsp_stable: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> $stable(rsp_contained) && $stable(rsp_polygon_index))
		else $error("rsp payload changed while stalled");

	a_miss_index: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_contained |-> rsp_polygon_index == '0)
		else $error("nonzero index on a miss");

	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && req_operation == OP_QUERY |=> !req_ready)
		else $error("req ready right after a query item");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && req_operation != OP_QUERY && !rsp_valid |=> !rsp_valid)
		else $error("result without a query");

endmodule

bind point_in_polygon_set pip_chk u_pip_chk (
	.clk               (clk),
	.arst_n            (arst_n),
	.req_valid         (req.valid),
	.req_ready         (req.ready),
	.req_operation     (req.operation),
	.rsp_valid         (rsp.valid),
	.rsp_ready         (rsp.ready),
	.rsp_contained     (rsp.contained),
	.rsp_polygon_index (rsp.polygon_index)
);

`default_nettype wire

### test/tb.sv
// Self-checking testbench for the point-in-polygon set: directed table, then random items.
`timescale 1ns / 1ps

module tb;
	import pip_pkg::*;

	localparam int MAX_VERTS  = 32;
	localparam int NUM_POLYS  = 8;
	localparam int COORD_BITS = 16;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int DRAIN_CYCLES = 400;
	localparam int RANDOM_ITEMS = 450;
	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

	typedef struct packed {
		logic [OP_W-1:0]           operation;
		logic [ID_W-1:0]           polygon_id;
		logic signed [COORD_W-1:0] coord_x;
		logic signed [COORD_W-1:0] coord_y;
	} pip_item_t;

	typedef struct packed {
		logic               contained;
		logic [INDEX_W-1:0] polygon_index;
	} pip_res_t;

	typedef struct packed {
		pip_item_t item;
		logic      typed;
		pip_res_t  res;
	} dir_row_t;

	localparam int DIR_ROWS = 23;
	dir_row_t dir_rows [DIR_ROWS] = '{
		'{'{OP_QUERY,  3'd0, 16'sd0, 16'sd0},             1'b1, '{1'b0, 3'd0}},
		'{'{OP_QUERY,  3'd0, -16'sd32768, 16'sd32767},    1'b1, '{1'b0, 3'd0}},
		'{'{OP_UNUSED, 3'd7, -16'sd1, -16'sd1},           1'b0, '{1'b0, 3'd0}},
		'{'{OP_APPEND, 3'd0, -16'sd256, -16'sd256},       1'b0, '{1'b0, 3'd0}},
		'{'{OP_APPEND, 3'd0, 16'sd256, -16'sd256},        1'b0, '{1'b0, 3'd0}},
		'{'{OP_APPEND, 3'd0, 16'sd256, 16'sd256},         1'b0, '{1'b0, 3'd0}},
		'{'{OP_APPEND, 3'd0, -16'sd256, 16'sd256},        1'b0, '{1'b0, 3'd0}},
		'{'{OP_QUERY,  3'd0, 16'sd0, 16'sd0},             1'b1, '{1'b1, 3'd0}},
		// on the left edge, on a corner, on a horizontal edge
		'{'{OP_QUERY,  3'd0, -16'sd256, 16'sd0},          1'b0, '{1'b0, 3'd0}},
		'{'{OP_QUERY,  3'd0, 16'sd256, 16'sd256},         1'b0, '{1'b0, 3'd0}},
		'{'{OP_QUERY,  3'd0, 16'sd0, 16'sd256},           1'b0, '{1'b0, 3'd0}},
		'{'{OP_APPEND, 3'd7, -16'sd32768, -16'sd32768},   1'b0, '{1'b0, 3'd0}},
		'{'{OP_APPEND, 3'd7, 16'sd32767, -16'sd32768},    1'b0, '{1'b0, 3'd0}},
		'{'{OP_APPEND, 3'd7, 16'sd0, 16'sd32767},         1'b0, '{1'b0, 3'd0}},
		'{'{OP_QUERY,  3'd0, 16'sd10000, 16'sd0},         1'b0, '{1'b0, 3'd0}},
		'{'{OP_QUERY,  3'd0, 16'sd32767, 16'sd32767},     1'b0, '{1'b0, 3'd0}},
		// one-vertex and two-vertex polygons
		'{'{OP_APPEND, 3'd3, 16'sd100, 16'sd100},         1'b0, '{1'b0, 3'd0}},
		'{'{OP_APPEND, 3'd5, -16'sd512, 16'sd0},          1'b0, '{1'b0, 3'd0}},
		'{'{OP_APPEND, 3'd5, 16'sd512, 16'sd0},           1'b0, '{1'b0, 3'd0}},
		'{'{OP_QUERY,  3'd0, 16'sd100, 16'sd100},         1'b0, '{1'b0, 3'd0}},
		'{'{OP_QUERY,  3'd0, -16'sd32768, -16'sd32768},   1'b0, '{1'b0, 3'd0}},
		'{'{OP_CLEAR,  3'd0, 16'sd0, 16'sd0},             1'b0, '{1'b0, 3'd0}},
		'{'{OP_QUERY,  3'd0, 16'sd0, 16'sd0},             1'b1, '{1'b0, 3'd0}}
	};

	logic clk;
	logic arst_n;
	int   cycles;
	int   errors;
	int   items_done;
	int   send_idle;
	int   rsp_stall;
	int   idle_tab [4] = '{0, 84, 0, 38};
	int   stall_tab [4] = '{0, 0, 84, 38};

	// predicted polygon store
	int vert_x [NUM_POLYS][MAX_VERTS];
	int vert_y [NUM_POLYS][MAX_VERTS];
	int vert_cnt [NUM_POLYS];
	// shape placement, used to aim queries
	int shape_cx [NUM_POLYS];
	int shape_cy [NUM_POLYS];
	int shape_r [NUM_POLYS];

	pip_res_t expected_hits [$];

	pip_req_if req_ch ();
	pip_rsp_if rsp_ch ();

	point_in_polygon_set #(
		.MAX_VERTS  (MAX_VERTS),
		.NUM_POLYS  (NUM_POLYS),
		.COORD_BITS (COORD_BITS)
	) u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	always @(negedge clk) begin
		rsp_ch.ready <= ($urandom_range(99) >= rsp_stall);
	end

	task automatic report_mismatch(input string what);
		$display("mismatch at cycle %0d: %s", cycles, what);
		errors++;
	endtask

	always @(posedge clk) begin
		pip_res_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (expected_hits.size() == 0) begin
				report_mismatch("result with no query pending");
			end else begin
				want = expected_hits.pop_front();
				if (rsp_ch.contained !== want.contained)
					report_mismatch($sformatf("contained %b, want %b",
						rsp_ch.contained, want.contained));
				if (rsp_ch.polygon_index !== want.polygon_index)
					report_mismatch($sformatf("polygon_index %0d, want %0d",
						rsp_ch.polygon_index, want.polygon_index));
			end
		end
	end

	function automatic bit edge_crossed(int x1, int y1, int x2, int y2, int px, int py);
		longint ex, ey, dy, s;
		ex = longint'(x2) - x1;
		ey = longint'(y2) - y1;
		dy = longint'(py) - y1;
		if (ey == 0)
			return 1'b0;
		s = (longint'(x1) - px) * ey + dy * ex;
		if (ey > 0)
			return dy >= 0 && dy <= ey && s >= 0;
		return dy <= 0 && dy >= ey && s <= 0;
	endfunction

	function automatic bit poly_inside(int p, int px, int py);
		int crossings;
		int k;
		crossings = 0;
		for (int j = 0; j < vert_cnt[p]; j++) begin
			k = (j + 1 == vert_cnt[p]) ? 0 : j + 1;
			if (edge_crossed(vert_x[p][j], vert_y[p][j], vert_x[p][k], vert_y[p][k], px, py))
				crossings++;
		end
		return crossings[0];
	endfunction

	// Updates the store; flags a query result and whether the item did anything.
	task automatic apply_item(input pip_item_t it, output bit has_res, output pip_res_t res,
			output bit acted);
		int p;
		has_res = 1'b0;
		res = '0;
		acted = 1'b0;
		case (it.operation)
			OP_CLEAR: begin
				for (int i = 0; i < NUM_POLYS; i++)
					vert_cnt[i] = 0;
				acted = 1'b1;
			end
			OP_APPEND: begin
				p = it.polygon_id;
				if (p < NUM_POLYS && vert_cnt[p] < MAX_VERTS) begin
					vert_x[p][vert_cnt[p]] = $signed(it.coord_x);
					vert_y[p][vert_cnt[p]] = $signed(it.coord_y);
					vert_cnt[p]++;
					acted = 1'b1;
				end
			end
			OP_QUERY: begin
				has_res = 1'b1;
				acted = 1'b1;
				for (int i = 0; i < NUM_POLYS; i++) begin
					if (!res.contained && poly_inside(i, $signed(it.coord_x), $signed(it.coord_y)))
						res = '{1'b1, INDEX_W'(i)};
				end
			end
			default: ;
		endcase
	endtask

	// Called at a falling edge; returns at a falling edge with valid still high.
	task automatic send_item(input pip_item_t it, input bit typed, input pip_res_t typed_res);
		bit has_res;
		bit acted;
		pip_res_t res;
		while ($urandom_range(99) < send_idle) begin
			req_ch.valid <= 1'b0;
			@(negedge clk);
		end
		req_ch.valid      <= 1'b1;
		req_ch.operation  <= it.operation;
		req_ch.polygon_id <= it.polygon_id;
		req_ch.coord_x    <= it.coord_x;
		req_ch.coord_y    <= it.coord_y;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		apply_item(it, has_res, res, acted);
		if (has_res)
			expected_hits.insert(expected_hits.size(), typed ? typed_res : res);
		if (acted)
			items_done++;
		@(negedge clk);
	endtask

	function automatic logic signed [COORD_W-1:0] sat16(int v);
		if (v > 32767)
			return 16'sd32767;
		if (v < -32768)
			return -16'sd32768;
		return COORD_W'(v);
	endfunction

	task automatic send(input logic [OP_W-1:0] op, input int id, input int x, input int y);
		send_item('{op, ID_W'(id), sat16(x), sat16(y)}, 1'b0, '0);
	endtask

	function automatic int spread(int r);
		return int'($urandom_range(2 * r)) - r;
	endfunction

	task automatic wait_drained();
		req_ch.valid <= 1'b0;
		@(negedge clk);
		while (expected_hits.size() != 0)
			@(negedge clk);
	endtask

	task automatic build_polygon();
		int id, n, pick;
		id = $urandom_range(NUM_POLYS - 1);
		pick = $urandom_range(99);
		if (pick < 90)
			n = $urandom_range(8, 3);
		else if (pick < 95)
			n = $urandom_range(2);
		else
			n = $urandom_range(34, 30);
		pick = $urandom_range(99);
		if (pick < 70) begin
			shape_r[id] = $urandom_range(400, 1);
			shape_cx[id] = spread(8000);
			shape_cy[id] = spread(8000);
		end else if (pick < 95) begin
			shape_r[id] = $urandom_range(6000, 400);
			shape_cx[id] = spread(16000);
			shape_cy[id] = spread(16000);
		end else begin
			shape_r[id] = 32768;
			shape_cx[id] = 0;
			shape_cy[id] = 0;
		end
		for (int i = 0; i < n; i++)
			send(OP_APPEND, id, shape_cx[id] + spread(shape_r[id]),
				shape_cy[id] + spread(shape_r[id]));
	endtask

	task automatic random_query();
		int pick, id, v;
		pick = $urandom_range(99);
		id = $urandom_range(NUM_POLYS - 1);
		if (pick < 50) begin
			send(OP_QUERY, 0, shape_cx[id] + spread(shape_r[id] * 5 / 4 + 1),
				shape_cy[id] + spread(shape_r[id] * 5 / 4 + 1));
		end else if (pick < 80 && vert_cnt[id] > 0) begin
			// exactly on a stored vertex, or one step off it
			v = $urandom_range(vert_cnt[id] - 1);
			if (pick < 65)
				send(OP_QUERY, 0, vert_x[id][v], vert_y[id][v]);
			else
				send(OP_QUERY, 0, vert_x[id][v] + spread(1), vert_y[id][v] + spread(1));
		end else begin
			send_item('{OP_QUERY, ID_W'($urandom), COORD_W'($urandom), COORD_W'($urandom)},
				1'b0, '0);
		end
	endtask

	task automatic random_step();
		int pick;
		pick = $urandom_range(99);
		if (pick < 4) begin
			send(OP_CLEAR, $urandom_range(NUM_POLYS - 1), spread(32768), spread(32768));
		end else if (pick < 40) begin
			build_polygon();
		end else if (pick < 90) begin
			repeat ($urandom_range(4, 1))
				random_query();
		end else if (pick < 95) begin
			send_item('{OP_UNUSED, ID_W'($urandom), COORD_W'($urandom), COORD_W'($urandom)},
				1'b0, '0);
		end else begin
			send_item('{OP_APPEND, ID_W'($urandom), COORD_W'($urandom), COORD_W'($urandom)},
				1'b0, '0);
		end
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		cycles = 0;
		errors = 0;
		items_done = 0;
		send_idle = 0;
		rsp_stall = 0;
		req_ch.valid = 1'b0;
		req_ch.operation = OP_CLEAR;
		req_ch.polygon_id = '0;
		req_ch.coord_x = '0;
		req_ch.coord_y = '0;
		rsp_ch.ready = 1'b0;
		for (int i = 0; i < NUM_POLYS; i++) begin
			vert_cnt[i] = 0;
			shape_cx[i] = 0;
			shape_cy[i] = 0;
			shape_r[i] = 256;
		end
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (int i = 0; i < DIR_ROWS; i++)
			send_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].res);
		wait_drained();

		items_done = 0;
		for (int ph = 0; ph < 4; ph++) begin
			send_idle = idle_tab[ph];
			rsp_stall = stall_tab[ph];
			while (items_done < (ph + 1) * RANDOM_ITEMS / 4) begin
				random_step();
				// hold off mid-phase until every result is back
				if (ph == 1 && items_done >= RANDOM_ITEMS * 3 / 8 &&
						items_done < RANDOM_ITEMS * 3 / 8 + 5)
					wait_drained();
			end
			wait_drained();
		end

		repeat (DRAIN_CYCLES) @(negedge clk);
		if (errors == 0 && expected_hits.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
